// ===== rtl/core/tclm_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tclm_pkg: shared types and constants of the three-channel level meter
// widths of the beat fields, the command queue entry and the divider states
// ----------------------------------------------------------------------------
package tclm_pkg;

	// channel and field widths
	localparam int NCH        = 3;
	localparam int SAMPLE_W   = 16;
	localparam int MAG_W      = 16;
	localparam int MEAN_W     = 16;
	localparam int STRIDE_W   = 16;
	localparam int CNT_W      = 64;
	localparam int KEPT_W     = 32;

	// default width of the magnitude sums
	localparam int SUM_WIDTH_DEF = 64;

	// depth of the command queue between front and back
	localparam int QUEUE_DEPTH = 2;

	// stream widths
	localparam int IN_TDATA_W  = NCH * SAMPLE_W;
	localparam int IN_TUSER_W  = 2;
	localparam int OUT_TDATA_W = STRIDE_W + KEPT_W + 2 * NCH * MAG_W;

	// tuser bit positions on the input side
	localparam int KIND_BIT  = 0;
	localparam int START_BIT = 1;

	// item kinds
	localparam logic KIND_SAMPLE = 1'b0;
	localparam logic KIND_TAKE   = 1'b1;

	// stride after reset
	localparam logic [STRIDE_W-1:0] STRIDE_RESET = 16'd1;

	// command handed from front to back
	typedef struct packed {
		logic                       take;
		logic [NCH-1:0][MAG_W-1:0]  mag;
	} cmd_t;

	// divider sequencer
	typedef enum logic [1:0] {
		DIV_IDLE,
		DIV_RUN,
		DIV_DONE
	} div_state_t;

endpackage
`default_nettype wire

// ===== rtl/core/tclm_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tclm_front: input beat intake and decimation
// holds the stride register and the phase, turns sample beats into magnitudes
// and pushes kept samples and take requests into the command queue
// ----------------------------------------------------------------------------
module tclm_front (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_valid,
	output      logic                            cfg_ready,
	input  wire logic [tclm_pkg::STRIDE_W-1:0]   cfg_data,
	input  wire logic                            s_tvalid,
	output      logic                            s_tready,
	input  wire logic [tclm_pkg::IN_TDATA_W-1:0] s_tdata,
	input  wire logic [tclm_pkg::IN_TUSER_W-1:0] s_tuser,
	input  wire logic                            q_full,
	output      logic                            push,
	output      tclm_pkg::cmd_t                  push_cmd,
	output      logic [tclm_pkg::STRIDE_W-1:0]   stride_eff
);
	import tclm_pkg::*;

	logic [STRIDE_W-1:0] stride_q;
	logic [STRIDE_W-1:0] phase_q;
	logic [STRIDE_W-1:0] ph_cur;
	logic [STRIDE_W:0]   ph_inc;
	logic [STRIDE_W-1:0] ph_next;
	logic                accept;
	logic                is_take;
	logic [SAMPLE_W-1:0] samp [NCH];

	// stride register, always ready
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stride_q <= STRIDE_RESET;
		end else if (cfg_valid) begin
			stride_q <= cfg_data;
		end
	end

	// a zero stride keeps every tick
	assign stride_eff = (stride_q == '0) ? STRIDE_RESET : stride_q;

	// beat classification
	assign s_tready = !q_full;
	assign accept   = s_tvalid && s_tready;
	assign is_take  = (s_tuser[KIND_BIT] == KIND_TAKE);

	// phase within the stride, restarted by block start
	always_comb begin
		ph_cur  = s_tuser[START_BIT] ? '0 : phase_q;
		ph_inc  = {1'b0, ph_cur} + {{STRIDE_W{1'b0}}, 1'b1};
		ph_next = (ph_inc >= {1'b0, stride_eff}) ? '0 : ph_inc[STRIDE_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= '0;
		end else if (accept && !is_take) begin
			phase_q <= ph_next;
		end
	end

	// magnitudes, most negative value gives 32768
	always_comb begin
		push_cmd.take = is_take;
		for (int ch = 0; ch < NCH; ch++) begin
			samp[ch]         = s_tdata[ch*SAMPLE_W +: SAMPLE_W];
			push_cmd.mag[ch] = samp[ch][SAMPLE_W-1] ? (~samp[ch] + 16'd1) : samp[ch];
		end
	end

	// dropped ticks never reach the queue
	assign push = accept && (is_take || (ph_cur == '0));

endmodule
`default_nettype wire

// ===== rtl/core/tclm_fifo.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tclm_fifo: short command queue
// decouples intake from accumulation so that either side can stall alone
// ----------------------------------------------------------------------------
module tclm_fifo (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push,
	input  wire tclm_pkg::cmd_t push_cmd,
	output      logic           full,
	input  wire logic           pop,
	output      tclm_pkg::cmd_t head_cmd,
	output      logic           empty
);
	import tclm_pkg::*;

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_QW = $clog2(QUEUE_DEPTH + 1);

	cmd_t               mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_QW-1:0]  count_q;

	assign full     = (count_q == CNT_QW'(QUEUE_DEPTH));
	assign empty    = (count_q == '0);
	assign head_cmd = mem_q[rd_ptr_q];

	// entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

// ===== rtl/core/tclm_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tclm_back: accumulators
// saturating magnitude sums, kept count and peaks; a take hands the totals
// to the divider and clears them in the same cycle
// ----------------------------------------------------------------------------
module tclm_back #(
	parameter int SUM_WIDTH = tclm_pkg::SUM_WIDTH_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        empty,
	input  wire tclm_pkg::cmd_t              head_cmd,
	output      logic                        pop,
	input  wire logic                        div_idle,
	output      logic                        div_start,
	output      logic [SUM_WIDTH-1:0]        sum [tclm_pkg::NCH],
	output      logic [tclm_pkg::MAG_W-1:0]  peak [tclm_pkg::NCH],
	output      logic [tclm_pkg::CNT_W-1:0]  count
);
	import tclm_pkg::*;

	logic [SUM_WIDTH-1:0] sum_q  [NCH];
	logic [MAG_W-1:0]     peak_q [NCH];
	logic [CNT_W-1:0]     cnt_q;
	logic [SUM_WIDTH:0]   sum_add [NCH];
	logic [SUM_WIDTH-1:0] sum_new [NCH];
	logic                 accum;

	// a take waits for the divider, a sample never waits
	assign pop       = !empty && (!head_cmd.take || div_idle);
	assign div_start = pop && head_cmd.take;
	assign accum     = pop && !head_cmd.take;

	// saturating adds, the sum is all ones at its limit
	always_comb begin
		for (int ch = 0; ch < NCH; ch++) begin
			sum_add[ch] = {1'b0, sum_q[ch]} + (SUM_WIDTH+1)'(head_cmd.mag[ch]);
			sum_new[ch] = sum_add[ch][SUM_WIDTH] ? '1 : sum_add[ch][SUM_WIDTH-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			for (int ch = 0; ch < NCH; ch++) begin
				sum_q[ch]  <= '0;
				peak_q[ch] <= '0;
			end
		end else if (div_start) begin
			cnt_q <= '0;
			for (int ch = 0; ch < NCH; ch++) begin
				sum_q[ch]  <= '0;
				peak_q[ch] <= '0;
			end
		end else if (accum) begin
			if (cnt_q != '1) begin
				cnt_q <= cnt_q + 1'b1;
			end
			for (int ch = 0; ch < NCH; ch++) begin
				sum_q[ch] <= sum_new[ch];
				if (head_cmd.mag[ch] > peak_q[ch]) begin
					peak_q[ch] <= head_cmd.mag[ch];
				end
			end
		end
	end

	assign sum   = sum_q;
	assign peak  = peak_q;
	assign count = cnt_q;

endmodule
`default_nettype wire

// ===== rtl/core/tclm_div.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tclm_div: summary unit
// captures the totals of a take, forms the three means by a restoring
// division of one quotient bit per cycle and holds the result beat
// ----------------------------------------------------------------------------
module tclm_div #(
	parameter int SUM_WIDTH = tclm_pkg::SUM_WIDTH_DEF
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             start,
	input  wire logic [tclm_pkg::STRIDE_W-1:0]    stride,
	input  wire logic [SUM_WIDTH-1:0]             sum [tclm_pkg::NCH],
	input  wire logic [tclm_pkg::MAG_W-1:0]       peak [tclm_pkg::NCH],
	input  wire logic [tclm_pkg::CNT_W-1:0]       count,
	output      logic                             idle,
	output      logic                             m_tvalid,
	input  wire logic                             m_tready,
	output      logic [tclm_pkg::OUT_TDATA_W-1:0] m_tdata
);
	import tclm_pkg::*;

	// the mean never exceeds the largest magnitude, so sixteen quotient bits do
	localparam int DEN_W  = CNT_W + MEAN_W - 1;
	localparam int STEP_W = $clog2(MEAN_W);

	div_state_t           state_q;
	div_state_t           state_d;
	logic [STEP_W-1:0]    step_q;
	logic [DEN_W-1:0]     den_q;
	logic [SUM_WIDTH-1:0] rem_q  [NCH];
	logic [MEAN_W-1:0]    quot_q [NCH];
	logic [MAG_W-1:0]     peak_q [NCH];
	logic [STRIDE_W-1:0]  stride_q;
	logic [KEPT_W-1:0]    kept_q;
	logic                 zero_q;
	logic [DEN_W-1:0]     rem_ext [NCH];
	logic [DEN_W-1:0]     diff    [NCH];
	logic                 ge      [NCH];
	logic [MEAN_W-1:0]    mean    [NCH];

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			DIV_IDLE: begin
				if (start) state_d = DIV_RUN;
			end
			DIV_RUN: begin
				if (step_q == '0) state_d = DIV_DONE;
			end
			DIV_DONE: begin
				if (m_tready) state_d = DIV_IDLE;
			end
			default: state_d = DIV_IDLE;
		endcase
	end

	// state outputs
	always_comb begin
		idle     = 1'b0;
		m_tvalid = 1'b0;
		case (state_q)
			DIV_IDLE: idle     = 1'b1;
			DIV_DONE: m_tvalid = 1'b1;
			default: begin
				idle     = 1'b0;
				m_tvalid = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= DIV_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// trial subtraction per channel
	always_comb begin
		for (int ch = 0; ch < NCH; ch++) begin
			rem_ext[ch] = DEN_W'(rem_q[ch]);
			ge[ch]      = (rem_ext[ch] >= den_q);
			diff[ch]    = rem_ext[ch] - den_q;
		end
	end

	// capture on start, one quotient bit per cycle while running
	always_ff @(posedge clk) begin
		if (start && (state_q == DIV_IDLE)) begin
			den_q    <= DEN_W'(count) << (MEAN_W - 1);
			step_q   <= STEP_W'(MEAN_W - 1);
			zero_q   <= (count == '0);
			stride_q <= stride;
			kept_q   <= (count > CNT_W'({KEPT_W{1'b1}})) ? '1 : count[KEPT_W-1:0];
			for (int ch = 0; ch < NCH; ch++) begin
				rem_q[ch]  <= sum[ch];
				quot_q[ch] <= '0;
				peak_q[ch] <= peak[ch];
			end
		end else if (state_q == DIV_RUN) begin
			den_q  <= den_q >> 1;
			step_q <= step_q - 1'b1;
			for (int ch = 0; ch < NCH; ch++) begin
				if (ge[ch]) begin
					rem_q[ch] <= diff[ch][SUM_WIDTH-1:0];
				end
				quot_q[ch] <= {quot_q[ch][MEAN_W-2:0], ge[ch]};
			end
		end
	end

	// result beat, an empty window reads as zero means
	always_comb begin
		for (int ch = 0; ch < NCH; ch++) begin
			mean[ch] = zero_q ? '0 : quot_q[ch];
		end
		m_tdata = {mean[2], mean[1], mean[0], peak_q[2], peak_q[1], peak_q[0],
			kept_q, stride_q};
	end

endmodule
`default_nettype wire

// ===== rtl/core/three_channel_level_meter_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// sample ticks pass the command queue register into the accumulators, one
// tick per cycle while the queue is not full; a take waits in the queue for
// an idle divider, and its summary shows on m_tvalid once the 16-step
// restoring divider has formed the three means, and holds until accepted
// reset: arst_n clears phase, sums, count, peaks and queue at once, sets the
// divider idle and returns the stride register to 1
// ----------------------------------------------------------------------------
// three_channel_level_meter_top: peak and mean absolute level meter
// three signed audio channels, decimated, summarised on each take beat
// ----------------------------------------------------------------------------
module three_channel_level_meter_top #(
	parameter int SUM_WIDTH = tclm_pkg::SUM_WIDTH_DEF
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	// configuration: decimation_stride
	input  wire logic                             cfg_valid,
	output      logic                             cfg_ready,
	input  wire logic [tclm_pkg::STRIDE_W-1:0]    cfg_data,
	input  wire logic                             s_tvalid,
	output      logic                             s_tready,
	// near_sample, reference_sample, clean_sample
	input  wire logic [tclm_pkg::IN_TDATA_W-1:0]  s_tdata,
	// kind, block_start
	input  wire logic [tclm_pkg::IN_TUSER_W-1:0]  s_tuser,
	output      logic                             m_tvalid,
	input  wire logic                             m_tready,
	// stride_used, kept_count, peak of near, reference, clean,
	// near_mean, reference_mean, clean_mean
	output      logic [tclm_pkg::OUT_TDATA_W-1:0] m_tdata
);
	import tclm_pkg::*;

	logic                q_full;
	logic                q_empty;
	logic                push;
	logic                pop;
	cmd_t                push_cmd;
	cmd_t                head_cmd;
	logic [STRIDE_W-1:0] stride_eff;
	logic                div_idle;
	logic                div_start;
	logic [SUM_WIDTH-1:0] sum  [NCH];
	logic [MAG_W-1:0]    peak [NCH];
	logic [CNT_W-1:0]    count;

	// intake and decimation
	tclm_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_data   (cfg_data),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.q_full     (q_full),
		.push       (push),
		.push_cmd   (push_cmd),
		.stride_eff (stride_eff)
	);

	// command queue
	tclm_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.full     (q_full),
		.pop      (pop),
		.head_cmd (head_cmd),
		.empty    (q_empty)
	);

	// accumulators
	tclm_back #(
		.SUM_WIDTH (SUM_WIDTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.empty     (q_empty),
		.head_cmd  (head_cmd),
		.pop       (pop),
		.div_idle  (div_idle),
		.div_start (div_start),
		.sum       (sum),
		.peak      (peak),
		.count     (count)
	);

	// means and result beat
	tclm_div #(
		.SUM_WIDTH (SUM_WIDTH)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.stride   (stride_eff),
		.sum      (sum),
		.peak     (peak),
		.count    (count),
		.idle     (div_idle),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

endmodule
`default_nettype wire

// ===== rtl/core/tclm_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tclm_checker: port-level checks of the level meter
// summary beat consistency and result hold under back-pressure
// ----------------------------------------------------------------------------
module tclm_checker (
	input wire logic                             clk,
	input wire logic                             arst_n,
	input wire logic                             m_tvalid,
	input wire logic                             m_tready,
	input wire logic [tclm_pkg::OUT_TDATA_W-1:0] m_tdata
);
	import tclm_pkg::*;

	localparam int KEPT_LO = STRIDE_W;
	localparam int PEAK_LO = STRIDE_W + KEPT_W;
	localparam int MEAN_LO = PEAK_LO + NCH * MAG_W;

	logic [STRIDE_W-1:0] stride_used;
	logic [KEPT_W-1:0]   kept;
	logic [MAG_W-1:0]    pk [NCH];
	logic [MEAN_W-1:0]   mn [NCH];

	always_comb begin
		stride_used = m_tdata[STRIDE_W-1:0];
		kept        = m_tdata[KEPT_LO +: KEPT_W];
		for (int ch = 0; ch < NCH; ch++) begin
			pk[ch] = m_tdata[PEAK_LO + ch*MAG_W +: MAG_W];
			mn[ch] = m_tdata[MEAN_LO + ch*MEAN_W +: MEAN_W];
		end
	end

	// a stalled summary beat holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("summary beat changed while stalled");

	// a mean magnitude never exceeds the peak of its channel
	a_mean_le_peak: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (mn[0] <= pk[0]) && (mn[1] <= pk[1]) && (mn[2] <= pk[2]))
		else $error("mean above peak");

	// an empty window reports zero peaks and zero means
	a_empty_window: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (kept == '0) |->
			(pk[0] == '0) && (pk[1] == '0) && (pk[2] == '0) &&
			(mn[0] == '0) && (mn[1] == '0) && (mn[2] == '0))
		else $error("empty window with non-zero levels");

	// the reported stride is never zero
	a_stride_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (stride_used != '0))
		else $error("zero stride reported");

endmodule

bind three_channel_level_meter_top tclm_checker u_tclm_checker (.*);
`default_nettype wire
